[rtl/tolr_pkg.sv]
// Shared constants, codes and types for the text overlay line renderer.
// No dependencies; tolr_line_seq, tolr_out_fifo and the top level import this package.
package tolr_pkg;

  // Screen and font geometry
  localparam int COLUMNS      = 30;
  localparam int ROWS         = 16;
  localparam int GLYPH_HEIGHT = 18;
  localparam int GLYPHS       = 256;

  localparam int SCREEN_CELLS = COLUMNS * ROWS;
  localparam int FONT_DEPTH   = GLYPHS * GLYPH_HEIGHT;
  localparam int SCR_AW       = (SCREEN_CELLS > 1) ? $clog2(SCREEN_CELLS) : 1;
  localparam int FONT_AW      = $clog2(FONT_DEPTH);
  localparam int COLCNT_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Port field widths
  localparam int CELL_W = 9;
  localparam int CODE_W = 8;
  localparam int GROW_W = 5;
  localparam int BITS_W = 16;
  localparam int LINE_W = 9;
  localparam int COL_W  = 5;
  localparam int PIX_W  = 12;

  // Font rows keep bits 2 to 13 of the written bitmap
  localparam int PIX_LSB = 2;

  // Scan line split: quotient by multiplication with a rounded-up reciprocal,
  // exact for every LINE_W-bit line number
  localparam int DIV_SHIFT = LINE_W + $clog2(GLYPH_HEIGHT);
  localparam int DIV_MULT  = (2 ** DIV_SHIFT + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;
  localparam int MULT_W    = DIV_SHIFT + 1;
  localparam int PROD_W    = LINE_W + MULT_W;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef enum logic [1:0] {
    OP_SCREEN_WR = 2'd0,
    OP_FONT_WR   = 2'd1,
    OP_RENDER    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIVIDE,
    SEQ_SPLIT,
    SEQ_RENDER
  } seq_state_t;

  // One column request from the sequencer into the read pipeline
  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  column;
    logic              last;
    logic              on_screen;
    logic [GROW_W-1:0] frow;
  } col_req_t;

  // One finished result transaction
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] plane0;
    logic [PIX_W-1:0] plane1;
    logic             last;
  } pix_item_t;

  function automatic logic [FONT_AW-1:0] font_addr(input logic [CODE_W-1:0] code,
                                                   input logic [GROW_W-1:0] row);
    font_addr = FONT_AW'(FONT_AW'(code) * FONT_AW'(GLYPH_HEIGHT) + FONT_AW'(row));
  endfunction

endpackage

[rtl/tolr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No dependencies.
module tolr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/tolr_line_seq.sv]
// Render sequencer: splits a scan line into text row and glyph row, then
// issues one screen read per column. Depends on tolr_pkg.
module tolr_line_seq
  import tolr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [LINE_W-1:0] line_number,
  input  logic              space_ok,
  output logic              busy,
  output logic [SCR_AW-1:0] scr_rd_addr,
  output col_req_t          req
);

  seq_state_t state, state_next;

  logic [LINE_W-1:0]   line;
  logic [LINE_W-1:0]   trow;
  logic [GROW_W-1:0]   frow;
  logic                on_screen;
  logic [SCR_AW-1:0]   base;
  logic [COLCNT_W-1:0] col;

  logic [PROD_W-1:0] prod;
  logic [LINE_W-1:0] quot;
  logic              issue;
  logic              col_last;

  assign prod     = PROD_W'(line) * PROD_W'(MULT_W'(DIV_MULT));
  assign quot     = LINE_W'(prod >> DIV_SHIFT);
  assign col_last = (col == COLCNT_W'(COLUMNS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      line <= line_number;
    end
    if (state == SEQ_DIVIDE) begin
      trow <= quot;
    end
    if (state == SEQ_SPLIT) begin
      frow      <= GROW_W'(line - LINE_W'(trow * LINE_W'(GLYPH_HEIGHT)));
      on_screen <= (int'(trow) < ROWS);
      base      <= SCR_AW'(SCR_AW'(trow) * SCR_AW'(COLUMNS));
      col       <= '0;
    end else if (issue) begin
      col <= COLCNT_W'(col + 1'b1);
    end
  end

  always_comb begin
    state_next    = state;
    issue         = 1'b0;
    busy          = (state != SEQ_IDLE);
    scr_rd_addr   = SCR_AW'(base + SCR_AW'(col));
    req.valid     = 1'b0;
    req.column    = COL_W'(col);
    req.last      = col_last;
    req.on_screen = on_screen;
    req.frow      = frow;
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_DIVIDE;
        end
      end
      SEQ_DIVIDE: begin
        state_next = SEQ_SPLIT;
      end
      SEQ_SPLIT: begin
        state_next = SEQ_RENDER;
      end
      SEQ_RENDER: begin
        issue     = space_ok;
        req.valid = space_ok;
        if (space_ok && col_last) begin
          state_next = SEQ_IDLE;
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

endmodule

[rtl/tolr_out_fifo.sv]
// Small result queue between the font read pipeline and the output channel.
// Depends on tolr_pkg; the writer never pushes into a full queue.
module tolr_out_fifo
  import tolr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pix_item_t          push_item,
  input  logic               out_stall,
  output logic               out_valid,
  output pix_item_t          head,
  output logic [FIFO_CW-1:0] count
);

  pix_item_t          entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= FIFO_AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= FIFO_AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= FIFO_CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= FIFO_CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/text_overlay_line_renderer.sv]
// Top level of the two-plane text overlay line renderer.
// Depends on tolr_pkg, tolr_ram, tolr_line_seq and tolr_out_fifo.
//
// The block holds a screen memory of COLUMNS x ROWS character codes and a font
// memory with 12 pixel bits per plane, glyph and glyph row; both start out
// undefined, so fill every cell and glyph row you will display before you
// render. A screen write (op 0) or font write (op 1) yields no result; writes
// to cells, glyphs or glyph rows beyond the geometry are dropped, as is op 3.
// A render transaction (op 2) names a scan line: the block takes the line in,
// does the reciprocal multiply, then forms the remainder and row base to split
// it into a text row and a glyph row, and then issues one column per cycle
// while the output queue has room; the input is stalled until the last column
// is issued. Each column passes a screen read and then a font read on two
// registered-read memories, and its result then enters the four-entry output
// queue. Column issue halts while the queue and the reads in flight would fill
// it, so out_stall throttles the line without loss. Every line yields COLUMNS
// results in column order, with last set on the final one; a line below the
// text area, or a stored code beyond the font, gives zero pixels. Pixel bit 0
// is the first pixel sent.
module text_overlay_line_renderer
  import tolr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [CELL_W-1:0] cell_index,
  input  logic [CODE_W-1:0] char_code,
  input  logic              glyph_plane,
  input  logic [GROW_W-1:0] glyph_row,
  input  logic [BITS_W-1:0] row_bits,
  input  logic [LINE_W-1:0] line_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  column,
  output logic [PIX_W-1:0]  plane0_pixels,
  output logic [PIX_W-1:0]  plane1_pixels,
  output logic              last
);

  logic busy;
  logic accept;
  logic start;

  // Write port side
  logic               scr_we;
  logic [SCR_AW-1:0]  scr_wr_addr;
  logic               font_ok;
  logic               font_we0;
  logic               font_we1;
  logic [FONT_AW-1:0] font_wr_addr;
  logic [PIX_W-1:0]   font_wr_data;

  // Read pipeline
  logic [SCR_AW-1:0]  scr_rd_addr;
  logic [CODE_W-1:0]  scr_rd_data;
  logic [FONT_AW-1:0] font_rd_addr;
  logic [PIX_W-1:0]   font0_rd_data;
  logic [PIX_W-1:0]   font1_rd_data;
  col_req_t           req;
  col_req_t           s1;
  logic               glyph_ok;
  logic               s2_valid;
  logic [COL_W-1:0]   s2_column;
  logic               s2_last;
  logic               s2_blank;
  logic               space_ok;

  // Output queue
  pix_item_t          push_item;
  pix_item_t          head;
  logic [FIFO_CW-1:0] fifo_count;

  // Hold the input while a line is being split or issued
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (op == OP_RENDER);

  // Writes go straight into the memories; drop those beyond the geometry
  assign scr_we       = accept && (op == OP_SCREEN_WR) && (int'(cell_index) < SCREEN_CELLS);
  assign scr_wr_addr  = SCR_AW'(cell_index);
  assign font_ok      = (int'(glyph_row) < GLYPH_HEIGHT) && (int'(char_code) < GLYPHS);
  assign font_we0     = accept && (op == OP_FONT_WR) && font_ok && !glyph_plane;
  assign font_we1     = accept && (op == OP_FONT_WR) && font_ok && glyph_plane;
  assign font_wr_addr = font_addr(char_code, glyph_row);
  assign font_wr_data = row_bits[PIX_LSB +: PIX_W];

  tolr_line_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .line_number (line_number),
    .space_ok    (space_ok),
    .busy        (busy),
    .scr_rd_addr (scr_rd_addr),
    .req         (req)
  );

  tolr_ram #(
    .WIDTH (CODE_W),
    .DEPTH (SCREEN_CELLS)
  ) u_screen_ram (
    .clk     (clk),
    .we      (scr_we),
    .wr_addr (scr_wr_addr),
    .wr_data (char_code),
    .rd_addr (scr_rd_addr),
    .rd_data (scr_rd_data)
  );

  // Stage 1: screen code is back; form the font address
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1 <= req;
    end
  end

  assign glyph_ok     = (int'(scr_rd_data) < GLYPHS);
  assign font_rd_addr = font_addr(scr_rd_data, s1.frow);

  // One font memory per colour plane, both read at the same glyph row
  tolr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FONT_DEPTH)
  ) u_font0_ram (
    .clk     (clk),
    .we      (font_we0),
    .wr_addr (font_wr_addr),
    .wr_data (font_wr_data),
    .rd_addr (font_rd_addr),
    .rd_data (font0_rd_data)
  );

  tolr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FONT_DEPTH)
  ) u_font1_ram (
    .clk     (clk),
    .we      (font_we1),
    .wr_addr (font_wr_addr),
    .wr_data (font_wr_data),
    .rd_addr (font_rd_addr),
    .rd_data (font1_rd_data)
  );

  // Stage 2: font rows are back; blank off-screen lines and codes beyond the font
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1.valid;
    end
    s2_column <= s1.column;
    s2_last   <= s1.last;
    s2_blank  <= !(s1.on_screen && glyph_ok);
  end

  assign push_item.column = s2_column;
  assign push_item.plane0 = s2_blank ? '0 : font0_rd_data;
  assign push_item.plane1 = s2_blank ? '0 : font1_rd_data;
  assign push_item.last   = s2_last;

  // Issue a column only if the queue can take it and everything in flight
  assign space_ok = (int'(fifo_count) + int'(s1.valid) + int'(s2_valid)) < FIFO_DEPTH;

  tolr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_item (push_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .count     (fifo_count)
  );

  assign column        = head.column;
  assign plane0_pixels = head.plane0;
  assign plane1_pixels = head.plane1;
  assign last          = head.last;

endmodule
